### design/rbe_pkg.sv
// Shared types and constants for the byte-wise rANS encoder.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbe_pkg;

  localparam int ALPHABET_SIZE_DEF = 256;
  localparam int PROB_BITS_DEF     = 12;

  localparam int KIND_W      = 2;
  localparam int SYM_W       = 8;
  localparam int SYM_RANGE   = 256;
  localparam int FREQ_W      = 12;
  localparam int BYTE_W      = 8;
  localparam int STATE_W     = 32;
  localparam int STATE_BYTES = STATE_W / BYTE_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [STATE_W-1:0] STATE_LOW = 32'h0001_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_FLUSH  = 1'b1
  } op_e;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    op_e               op;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] cum;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

### design/rbe_front.sv
// Front end: accepts input beats, holds the frequency/cumulative table and
// turns encode and flush items into commands for the queue. Uses rbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbe_front
  import rbe_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [FREQ_W-1:0] freq_i,
  input  wire logic [FREQ_W-1:0] cum_start_i,
  input  wire qstat_t            qstat_i,
  output logic                   push_o,
  output cmd_t                   cmd_o
);

  localparam int TBL_DEPTH = (ALPHABET_SIZE > SYM_RANGE) ? SYM_RANGE : ALPHABET_SIZE;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int ENTRY_W   = 2 * FREQ_W;

  logic [ENTRY_W-1:0] tbl_mem [TBL_DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  logic     s1_valid_q, s1_valid_d;
  op_e      s1_op_q, s1_op_d;
  logic     in_range, accept, s1_live, s1_adv, do_load;
  logic [IDX_W-1:0] idx;
  logic [FREQ_W-1:0] rd_freq, rd_cum;

  assign idx      = symbol_i[IDX_W-1:0];
  assign in_range = (32'(symbol_i) < ALPHABET_SIZE);
  assign rd_freq  = rd_q[ENTRY_W-1:FREQ_W];
  assign rd_cum   = rd_q[FREQ_W-1:0];

  // An encode whose entry holds a zero frequency is dropped here.
  assign s1_live    = s1_valid_q && (s1_op_q == OP_FLUSH || rd_freq != '0);
  assign s1_adv     = !s1_live || !qstat_i.full;
  assign in_stall_o = !s1_adv;
  assign accept     = in_valid_i && s1_adv;

  assign push_o = s1_live && !qstat_i.full;
  assign cmd_o  = '{op: s1_op_q, freq: rd_freq, cum: rd_cum};

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_op_d    = s1_op_q;
    do_load    = 1'b0;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
      if (accept) begin
        unique case (kind_e'(kind_i))
          KIND_LOAD: begin
            do_load = in_range;
          end
          KIND_ENCODE: begin
            s1_valid_d = in_range;
            s1_op_d    = OP_ENCODE;
          end
          KIND_FLUSH: begin
            s1_valid_d = 1'b1;
            s1_op_d    = OP_FLUSH;
          end
          default: begin
            s1_valid_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_op_q    <= OP_ENCODE;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_op_q    <= s1_op_d;
    end
  end

  // The read port only moves on an accepted beat, so a held stage keeps its entry.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      tbl_mem[idx] <= {freq_i, cum_start_i};
    end
    if (accept) begin
      rd_q <= tbl_mem[idx];
    end
  end

endmodule

`default_nettype wire

### design/rbe_queue.sv
// Short command queue between the front end and the back end.
// Uses cmd_t and qstat_t from rbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbe_queue
  import rbe_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire cmd_t   cmd_i,
  input  wire logic   pop_i,
  output cmd_t        cmd_o,
  output qstat_t      qstat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign cmd_o         = q_mem[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

### design/rbe_back.sv
// Back end: holds the coder state, renormalises and emits bytes, runs the
// radix-2 division and performs the state update and flush. Uses rbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbe_back
  import rbe_pkg::*;
#(
  parameter int PROB_BITS = PROB_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire qstat_t            qstat_i,
  input  wire cmd_t              cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   last_o
);

  localparam int LIMIT_SHIFT = STATE_W - BYTE_W - PROB_BITS;
  localparam int CNT_W       = $clog2(STATE_W);
  localparam int BIDX_W      = $clog2(STATE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RENORM,
    ST_DIVIDE,
    ST_UPDATE,
    ST_FLUSH
  } state_e;

  state_e             state_q;
  logic [STATE_W-1:0] x_q, limit_q;
  logic [FREQ_W-1:0]  freq_q, cum_q, rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               out_valid_q, last_q;
  logic [BYTE_W-1:0]  out_byte_q;

  logic               can_emit, ge, next_ge, renorm_last, flush_last, trial_ok;
  logic [FREQ_W:0]    trial, diff;
  logic [STATE_W-1:0] update;

  assign can_emit    = !out_valid_q || !out_stall_i;
  assign ge          = (x_q >= limit_q);
  assign next_ge     = ((x_q >> BYTE_W) >= limit_q);
  assign renorm_last = !next_ge || (cnt_q[BIDX_W-1:0] == BIDX_W'(STATE_BYTES - 1));
  assign flush_last  = (cnt_q[BIDX_W-1:0] == BIDX_W'(STATE_BYTES - 1));

  // Restoring division step: the quotient shifts into x_q from the bottom.
  assign trial    = {rem_q, x_q[STATE_W-1]};
  assign trial_ok = (trial >= {1'b0, freq_q});
  assign diff     = trial - {1'b0, freq_q};

  assign update = (x_q << PROB_BITS) + STATE_W'(rem_q) + STATE_W'(cum_q);

  assign pop_o       = (state_q == ST_IDLE) && !qstat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= STATE_LOW;
      limit_q     <= '0;
      freq_q      <= '0;
      cum_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!qstat_i.empty) begin
            freq_q  <= cmd_i.freq;
            cum_q   <= cmd_i.cum;
            limit_q <= STATE_W'(cmd_i.freq) << LIMIT_SHIFT;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= (cmd_i.op == OP_FLUSH) ? ST_FLUSH : ST_RENORM;
          end
        end
        ST_RENORM: begin
          if (ge) begin
            if (can_emit) begin
              out_valid_q <= 1'b1;
              out_byte_q  <= x_q[BYTE_W-1:0];
              last_q      <= renorm_last;
              x_q         <= x_q >> BYTE_W;
              if (renorm_last) begin
                cnt_q   <= '0;
                state_q <= ST_DIVIDE;
              end else begin
                cnt_q <= cnt_q + 1'b1;
              end
            end
          end else begin
            cnt_q   <= '0;
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          x_q   <= {x_q[STATE_W-2:0], trial_ok};
          rem_q <= trial_ok ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(STATE_W - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          x_q     <= update;
          state_q <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (can_emit) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= x_q[BYTE_W-1:0];
            last_q      <= flush_last;
            cnt_q       <= cnt_q + 1'b1;
            if (flush_last) begin
              x_q     <= STATE_LOW;
              state_q <= ST_IDLE;
            end else begin
              x_q <= x_q >> BYTE_W;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/rans_byte_encoder.sv
// Static-model 32-bit rANS encoder with byte renormalisation.
// Load beats are taken one per cycle while in_stall_o is low. An encode item
// occupies the back end for a pop, up to three byte beats, 32 radix-2 division
// steps and an update; a flush occupies it for a pop and four byte beats.
// Reset is asynchronous, active low: the state returns to 65536, the queue
// empties; the symbol table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module rans_byte_encoder
  import rbe_pkg::*;
#(
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int PROB_BITS     = PROB_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [KIND_W-1:0] kind_i,
  input  wire logic [SYM_W-1:0]  symbol_i,
  input  wire logic [FREQ_W-1:0] freq_i,
  input  wire logic [FREQ_W-1:0] cum_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [BYTE_W-1:0]      out_byte_o,
  output logic                   last_o
);

  cmd_t   push_cmd, q_cmd;
  qstat_t qstat;
  logic   push, pop;

  rbe_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .symbol_i   (symbol_i),
    .freq_i     (freq_i),
    .cum_start_i(cum_start_i),
    .qstat_i    (qstat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  rbe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (q_cmd),
    .qstat_o(qstat)
  );

  rbe_back #(
    .PROB_BITS(PROB_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .cmd_i      (q_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

### design/rbe_checker.sv
// Port-level checks for the rANS encoder, bound to the top level.
// Uses rbe_pkg for widths; sees only the ports of rans_byte_encoder.
`timescale 1ns / 1ps
`default_nettype none

module rbe_checker
  import rbe_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [BYTE_W-1:0] out_byte_o,
  input wire logic              last_o
);

  localparam int GRP_W = $clog2(STATE_BYTES);

  logic [GRP_W-1:0] grp_cnt_q;
  logic             out_beat;

  assign out_beat = out_valid_o && !out_stall_i;

  // Bytes delivered since the previous beat that carried last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_cnt_q <= '0;
    end else if (out_beat) begin
      grp_cnt_q <= last_o ? '0 : grp_cnt_q + 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  a_group_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && grp_cnt_q == GRP_W'(STATE_BYTES - 1) |-> last_o)
    else $error("more than four bytes without last");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat offered straight out of reset");

  a_no_x_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_stall_o))
    else $error("input stall unknown while valid is high");

endmodule

bind rans_byte_encoder rbe_checker u_rbe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o),
  .last_o     (last_o)
);

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for rans_byte_encoder: loads symbol tables, encodes runs and
// flushes, and predicts every stream byte as each input beat is taken.
// Depends on rbe_pkg and the rans_byte_encoder design.

module testbench;
  import rbe_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int ITEM_TARGET    = 450;
  localparam int HOLDOFF_START  = 120;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int PROB_ONE       = 1 << PROB_BITS_DEF;
  localparam int FREQ_MAX       = (1 << FREQ_W) - 1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] freq;
    logic [FREQ_W-1:0] cum;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } stream_byte_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [KIND_W-1:0] kind_i      = '0;
  logic [SYM_W-1:0]  symbol_i    = '0;
  logic [FREQ_W-1:0] freq_i      = '0;
  logic [FREQ_W-1:0] cum_start_i = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_o;

  // Encoder state as the bench predicts it.
  logic [STATE_W-1:0] enc_state = STATE_LOW;
  logic [FREQ_W-1:0]  freq_tbl [SYM_RANGE];
  logic [FREQ_W-1:0]  cum_tbl  [SYM_RANGE];

  item_t          pending_items[$];
  stream_byte_t   stream_q[$];
  bit             sym_loaded [SYM_RANGE];
  logic [SYM_W-1:0] loaded_syms[$];
  int             queued_count = 0;
  int             items_taken  = 0;
  int             mismatches   = 0;

  item_t          beat_in;
  item_t          beat_next;
  stream_byte_t   want;
  int             burst_left   = 0;
  int             gap_left     = 0;
  int             holdoff_left = 0;
  bit             holdoff_done = 1'b0;
  int             stall_mode   = 0;
  int             mode_left    = 0;

  rans_byte_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .symbol_i    (symbol_i),
    .freq_i      (freq_i),
    .cum_start_i (cum_start_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Works out the stream bytes one taken beat produces and advances the state.
  task automatic predict_stream(input item_t it);
    logic [STATE_W-1:0] x;
    logic [FREQ_W-1:0]  f;
    logic [63:0]        bound;
    logic [63:0]        upd;
    stream_byte_t       b;
    int                 n;
    n = 0;
    x = enc_state;
    if (it.kind == KIND_LOAD) begin
      freq_tbl[it.symbol] = it.freq;
      cum_tbl[it.symbol]  = it.cum;
    end else if (it.kind == KIND_ENCODE && freq_tbl[it.symbol] != '0) begin
      f = freq_tbl[it.symbol];
      bound = 64'(f) << (24 - PROB_BITS_DEF);
      while (64'(x) >= bound && n < STATE_BYTES) begin
        b.data = x[BYTE_W-1:0];
        x = x >> BYTE_W;
        n++;
        b.last = !(64'(x) >= bound && n < STATE_BYTES);
        stream_q.insert(stream_q.size(), b);
      end
      // Even an inconsistent table cannot make the update overflow the state.
      upd = (64'(x / 32'(f)) << PROB_BITS_DEF) + 64'(x % 32'(f)) + 64'(cum_tbl[it.symbol]);
      enc_state = upd[STATE_W-1:0];
    end else if (it.kind == KIND_FLUSH) begin
      for (int i = 0; i < STATE_BYTES; i++) begin
        b.data = x[BYTE_W-1:0];
        b.last = (i == STATE_BYTES - 1);
        stream_q.insert(stream_q.size(), b);
        x = x >> BYTE_W;
      end
      enc_state = STATE_LOW;
    end
  endtask

  task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                            input int f, input int c);
    item_t it;
    it.kind   = kind;
    it.symbol = sym;
    it.freq   = FREQ_W'(f);
    it.cum    = FREQ_W'(c);
    pending_items.insert(pending_items.size(), it);
    if (kind == KIND_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), sym);
    end
    if (kind != KIND_UNUSED) queued_count++;
  endtask

  // Sender: bursts of beats separated by random gaps; a stalled beat is held.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      kind_i      <= '0;
      symbol_i    <= '0;
      freq_i      <= '0;
      cum_start_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        beat_in = '{kind_i, symbol_i, freq_i, cum_start_i};
        predict_stream(beat_in);
        items_taken <= items_taken + 1;
      end
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        beat_next = pending_items.pop_front();
        in_valid_i  <= 1'b1;
        kind_i      <= beat_next.kind;
        symbol_i    <= beat_next.symbol;
        freq_i      <= beat_next.freq;
        cum_start_i <= beat_next.cum;
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: changing patterns, plus one long hold-off to fill the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else if (!holdoff_done && items_taken >= HOLDOFF_START) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 7) == 0);
        2:       out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stream_q.size() == 0) begin
        $display("%0t: unexpected byte %02h last %b", $time, out_byte_o, last_o);
        mismatches++;
      end else begin
        want = stream_q.pop_front();
        if (out_byte_o !== want.data) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.data, out_byte_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b, got %b", $time, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [SYM_W-1:0] table_syms[$];
    bit               in_table [SYM_RANGE];
    logic [SYM_W-1:0] s;
    int               k;
    int               remaining;
    int               hi;
    int               f;

    // Directed: field extremes, every kind, zero frequency, unused kind and an
    // inconsistent table entry.
    queue_item(KIND_LOAD, 8'd0, FREQ_MAX, 0);
    queue_item(KIND_LOAD, 8'd255, 1, PROB_ONE - 1);
    queue_item(KIND_ENCODE, 8'd0, 0, 0);
    queue_item(KIND_ENCODE, 8'd255, FREQ_MAX, FREQ_MAX);
    queue_item(KIND_ENCODE, 8'd255, 0, 0);
    queue_item(KIND_ENCODE, 8'd0, 0, 0);
    queue_item(KIND_FLUSH, 8'd0, 0, 0);
    queue_item(KIND_UNUSED, 8'hAA, FREQ_MAX, FREQ_MAX);
    queue_item(KIND_LOAD, 8'd7, 0, 123);
    queue_item(KIND_ENCODE, 8'd7, 0, 0);
    queue_item(KIND_LOAD, 8'd128, FREQ_MAX, FREQ_MAX);
    queue_item(KIND_ENCODE, 8'd128, 0, 0);
    queue_item(KIND_ENCODE, 8'd128, 0, 0);
    queue_item(KIND_ENCODE, 8'd128, 0, 0);
    queue_item(KIND_ENCODE, 8'd255, 0, 0);
    queue_item(KIND_ENCODE, 8'd255, 0, 0);
    queue_item(KIND_FLUSH, 8'hFF, FREQ_MAX, FREQ_MAX);
    queue_item(KIND_FLUSH, 8'd0, 0, 0);
    queue_item(KIND_LOAD, 8'd170, PROB_ONE / 2, PROB_ONE / 2);
    queue_item(KIND_LOAD, 8'd85, PROB_ONE / 2, 0);
    queue_item(KIND_ENCODE, 8'd170, 0, 0);
    queue_item(KIND_ENCODE, 8'd85, 0, 0);
    queue_item(KIND_ENCODE, 8'd170, 0, 0);
    queue_item(KIND_FLUSH, 8'd0, 0, 0);

    // Random: mostly a fresh normalised table followed by a run of its symbols,
    // with noise loads, unused kinds and stray encodes mixed in.
    while (queued_count < ITEM_TARGET) begin
      table_syms.delete();
      foreach (in_table[i]) in_table[i] = 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        s = SYM_W'($urandom_range(0, SYM_RANGE - 1));
        table_syms.insert(table_syms.size(), s);
        queue_item(KIND_LOAD, s, FREQ_MAX, $urandom_range(0, 1));
      end else begin
        k = $urandom_range(2, 12);
        remaining = PROB_ONE;
        for (int i = 0; i < k; i++) begin
          do s = SYM_W'($urandom_range(0, SYM_RANGE - 1)); while (in_table[s]);
          in_table[s] = 1'b1;
          table_syms.insert(table_syms.size(), s);
          if (i == k - 1) begin
            f = remaining;
          end else begin
            hi = remaining - (k - 1 - i);
            if ($urandom_range(0, 1) == 1 && hi > 32) hi = 32;
            f = $urandom_range(1, hi);
          end
          queue_item(KIND_LOAD, s, f, PROB_ONE - remaining);
          remaining -= f;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0: queue_item(KIND_LOAD, SYM_W'($urandom_range(0, SYM_RANGE - 1)),
                          $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX));
            1: queue_item(KIND_UNUSED, SYM_W'($urandom_range(0, SYM_RANGE - 1)),
                          $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX));
            default: queue_item(KIND_ENCODE,
                                loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                                $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX));
          endcase
        end
      end
      repeat ($urandom_range(4, 40)) begin
        queue_item(KIND_ENCODE, table_syms[$urandom_range(0, table_syms.size() - 1)],
                   $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX));
      end
      // Now and then the state carries over into the next table.
      if ($urandom_range(0, 3) != 0) begin
        queue_item(KIND_FLUSH, SYM_W'($urandom_range(0, SYM_RANGE - 1)),
                   $urandom_range(0, FREQ_MAX), $urandom_range(0, FREQ_MAX));
      end
    end
    queue_item(KIND_FLUSH, 8'd0, 0, 0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (stream_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && stream_q.size() == 0) begin
      $display("rans_byte_encoder verification clean");
    end else begin
      $display("rans_byte_encoder verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rans_byte_encoder verification failed");
    $finish;
  end

endmodule

### sim.f
design/rbe_pkg.sv
design/rbe_front.sv
design/rbe_queue.sv
design/rbe_back.sv
design/rans_byte_encoder.sv
design/rbe_checker.sv
bench/testbench.sv
